>>> rtl/shifting_array_table_macros.svh
// Assertion macros used by the shifting array table checker.
`ifndef SHIFTING_ARRAY_TABLE_MACROS_SVH
`define SHIFTING_ARRAY_TABLE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define SAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sat_pkg.sv
// Types and codes shared by the shifting array table and its checker.
`timescale 1ns / 1ps
package sat_pkg;

	typedef enum logic [2:0] {
		ACT_INSERT     = 3'd0,
		ACT_ERASE      = 3'd1,
		ACT_PUSH_FRONT = 3'd2,
		ACT_PUSH_BACK  = 3'd3,
		ACT_POP_FRONT  = 3'd4,
		ACT_POP_BACK   = 3'd5,
		ACT_GET        = 3'd6,
		ACT_SET        = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [6:0]  position;
		logic [31:0] write_value;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic [6:0]  element_count;
	} result_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;   // open a gap at the position, tail moves up
		logic del;   // close the gap at the position, tail moves down
		logic wr;    // overwrite the element at the position
	} cell_cmd_t;

endpackage

>>> rtl/shifting_array_table.sv
// Top level of the shifting array table: control, count and the row of cells.
`timescale 1ns / 1ps
// Ordered array of up to CAPACITY elements held in a row of cells.
// Request channel: drive request and raise start; the beat is taken at a
// rising edge with start high and busy low. busy stays low, so a request
// can be taken in every cycle.
// Result channel: done is high for exactly one cycle, the cycle after the
// request was taken, with result valid in that cycle. The receiver cannot
// stall; a result must be taken when done is high.
// Throughput is one request per cycle for every action: on insert and
// erase every cell loads its neighbor in parallel, so the whole tail
// shifts at once.
// A rejected request leaves the store and the count unchanged.
// Reset (arst_n low) clears the count and the result strobe. Cell contents
// are not cleared; only cells below the count are ever read.
module shifting_array_table
	import sat_pkg::*;
#(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int EW   = ELEMENT_WIDTH;
	localparam int WIDE = (EW > 32) ? EW : 32;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_next;
	logic            done_q;
	result_t         result_q;

	logic            accept;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic            full;
	logic            empty;
	logic            in_range;
	logic            ins_ok;
	cell_cmd_t       cmd;
	logic [CMPW-1:0] cmd_pos;
	status_t         status;
	logic            read_ok;
	logic [WIDE-1:0] wv_wide;
	logic [EW-1:0]   wdata;
	logic [EW-1:0]   rd_sel;
	logic [WIDE-1:0] rd_wide;
	logic [EW-1:0]   cell_data [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign pos_x    = CMPW'(request.position);
	assign cnt_x    = CMPW'(cnt_q);
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign in_range = (pos_x < cnt_x);
	assign ins_ok   = (pos_x <= cnt_x);

	assign wv_wide = WIDE'(request.write_value);
	assign wdata   = wv_wide[EW-1:0];

	always_comb begin
		cmd      = '0;
		cmd_pos  = pos_x;
		status   = ST_OK;
		read_ok  = 1'b0;
		cnt_next = cnt_q;
		unique case (request.action)
			ACT_INSERT: begin
				if (!ins_ok) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins  = 1'b1;
					cnt_next = cnt_q + 1'b1;
				end
			end
			ACT_ERASE: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					cmd.del  = 1'b1;
					cnt_next = cnt_q - 1'b1;
				end
			end
			ACT_PUSH_FRONT: begin
				cmd_pos = '0;
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins  = 1'b1;
					cnt_next = cnt_q + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				cmd_pos = cnt_x;
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins  = 1'b1;
					cnt_next = cnt_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				cmd_pos = '0;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.del  = 1'b1;
					cnt_next = cnt_q - 1'b1;
				end
			end
			ACT_POP_BACK: begin
				// drop the last element by shrinking the count only
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cnt_next = cnt_q - 1'b1;
				end
			end
			ACT_GET: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					read_ok = 1'b1;
				end
			end
			ACT_SET: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					cmd.wr = 1'b1;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
		if (!accept) begin
			cmd = '0;
		end
	end

	// AND-OR select of the addressed cell for get
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_sel = rd_sel | (cell_data[i] & {EW{pos_x == CMPW'(i)}});
		end
	end

	assign rd_wide = WIDE'(rd_sel);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [EW-1:0] lower;
		logic [EW-1:0] upper;

		if (g == 0) begin : g_first
			assign lower = wdata;
		end else begin : g_mid_lo
			assign lower = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign upper = cell_data[g];
		end else begin : g_mid_hi
			assign upper = cell_data[g+1];
		end

		sat_cell #(
			.IDX  (g),
			.EW   (EW),
			.CMPW (CMPW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (cmd_pos),
			.wdata (wdata),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.status        <= status;
			result_q.read_value    <= read_ok ? rd_wide[31:0] : 32'd0;
			result_q.element_count <= 7'(cnt_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/sat_cell.sv
// One element cell: holds a value, takes a neighbor's or new data on command.
`timescale 1ns / 1ps
module sat_cell
	import sat_pkg::*;
#(
	parameter int IDX  = 0,
	parameter int EW   = 32,
	parameter int CMPW = 7
) (
	input  logic            clk,
	input  cell_cmd_t       cmd,
	input  logic [CMPW-1:0] pos,
	input  logic [EW-1:0]   wdata,
	input  logic [EW-1:0]   lower,
	input  logic [EW-1:0]   upper,
	output logic [EW-1:0]   data
);

	localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

	logic [EW-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (cmd.ins) begin
			if (MY_IDX > pos) begin
				data_q <= lower;
			end else if (MY_IDX == pos) begin
				data_q <= wdata;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= pos) begin
				data_q <= upper;
			end
		end else if (cmd.wr) begin
			if (MY_IDX == pos) begin
				data_q <= wdata;
			end
		end
	end

	assign data = data_q;

endmodule

>>> rtl/sat_checker.sv
// Port-level checks for the shifting array table, bound to the top level.
`timescale 1ns / 1ps
`include "shifting_array_table_macros.svh"
module sat_checker
	import sat_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     done,
	input result_t  result
);

	`SAT_ASSERT_NEXT(a_beat_gets_result, clk, arst_n, start && !busy, done, "beat taken without result")
	`SAT_ASSERT_NOW(a_result_has_beat, clk, arst_n, done, $past(start && !busy), "result without beat")
	`SAT_ASSERT_NOW(a_empty_count, clk, arst_n, done && result.status == ST_EMPTY, result.element_count == 7'd0, "empty status with nonzero count")
	`SAT_ASSERT_NOW(a_full_count, clk, arst_n, done && result.status == ST_FULL, result.element_count == 7'(CAPACITY), "full status below capacity")
	`SAT_ASSERT_NOW(a_read_only_get, clk, arst_n, done && result.read_value != 32'd0, result.status == ST_OK && $past(request.action) == ACT_GET, "read data on non-get result")

endmodule

bind shifting_array_table sat_checker #(
	.CAPACITY (CAPACITY)
) u_sat_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);
